[src/crosspoint_relay_matrix_controller_assert.svh]
// Assertion macros for the relay matrix controller top level.
`ifndef CROSSPOINT_RELAY_MATRIX_CONTROLLER_ASSERT_SVH
`define CROSSPOINT_RELAY_MATRIX_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/crm_pkg.sv]
// Types and constants shared by the relay matrix controller.
package crm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [2:0] ACT_CONNECT    = 3'd0;
  localparam logic [2:0] ACT_DISCONNECT = 3'd1;
  localparam logic [2:0] ACT_SET_LEVEL  = 3'd2;
  localparam logic [2:0] ACT_CLEAR_ALL  = 3'd3;
  localparam logic [2:0] ACT_TICK       = 3'd4;

  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_CLOSE   = 3'd1;
  localparam logic [2:0] CMD_OPEN    = 3'd2;
  localparam logic [2:0] CMD_SET     = 3'd3;
  localparam logic [2:0] CMD_RELEASE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LATCHING   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LOCKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_COLS  = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  row;
    logic [4:0]  col;
    logic [15:0] level;
  } crm_in_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  cmd_row;
    logic [3:0]  cmd_col;
    logic [15:0] cmd_level;
    logic        accepted;
    logic        last;
  } crm_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DECIDE,
    ST_CLR,
    ST_CLR_LAST,
    ST_TK_RD,
    ST_TK_CHK,
    ST_TK_WR,
    ST_FIN
  } crm_state_t;

endpackage

[src/crm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module crm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/crosspoint_relay_matrix_controller.sv]
// Top level of the crosspoint relay matrix controller: node map, pulse table and sequencer.
//
//   Channel  Ports                              Handshake
//   input    start, busy, in_req                beat taken when start is high and busy low
//   result   out_strobe, out_res                one beat per strobe cycle, no back-pressure
//   config   cfg_we, cfg_index, cfg_data        register written when cfg_we is high
//
// Connect, disconnect and set level make one map read per live row on the node's column,
// limited by the single read port of the node map.
// Clear all reads live_rows * live_cols nodes, one node per cycle through the same port.
// In latching mode a tick reads every pulse slot and writes back the node of each expired one.
// Reset is synchronous; per-entry valid bits stand for the cleared map, so no clearing pass.
// Results cannot be stalled; each one is shown for a single cycle.
module crosspoint_relay_matrix_controller
  import crm_pkg::*;
#(
  parameter int MAX_ROWS    = 4,
  parameter int MAX_COLS    = 16,
  parameter int PULSE_SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  crm_in_t               in_req,
  output logic                  out_strobe,
  output crm_out_t              out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "crosspoint_relay_matrix_controller_assert.svh"

  localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW        = (PULSE_SLOTS > 1) ? $clog2(PULSE_SLOTS) : 1;
  localparam int MAP_AW    = RW + CW;
  localparam int MAP_DEPTH = 1 << MAP_AW;
  localparam int MW        = SW + 2;
  localparam int PW        = RW + CW + 32;
  localparam int E_CLOSED  = 0;
  localparam int E_PEND    = 1;

  // Configuration registers.
  logic        latching_r;
  logic [15:0] pulse_ticks_r;
  logic [2:0]  rows_in_use_r;
  logic [4:0]  cols_in_use_r;
  logic [15:0] row_lock_r;
  logic [15:0] excl_cols_r;

  crm_state_t state_r, state_nxt;
  logic [2:0]             act_r, act_nxt;
  logic [RW-1:0]          req_row_r, req_row_nxt;
  logic [CW-1:0]          req_col_r, req_col_nxt;
  logic [15:0]            level_r, level_nxt;
  logic                   rng_r, rng_nxt;
  logic                   blk_r, blk_nxt;
  logic [MW-1:0]          tgt_r, tgt_nxt;
  logic [RW-1:0]          scan_r, scan_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [RW-1:0]          chk_row_r, chk_row_nxt;
  logic [RW-1:0]          cr_r, cr_nxt;
  logic [CW-1:0]          cc_r, cc_nxt;
  logic                   clr_vld_r, clr_vld_nxt;
  logic [RW-1:0]          clr_row_r, clr_row_nxt;
  logic [CW-1:0]          clr_col_r, clr_col_nxt;
  logic [SW-1:0]          slot_r, slot_nxt;
  logic [RW-1:0]          tk_row_r, tk_row_nxt;
  logic [CW-1:0]          tk_col_r, tk_col_nxt;
  logic [31:0]            tick_r, tick_nxt;
  logic [PULSE_SLOTS-1:0] act_vec_r, act_vec_nxt;
  logic                   held_vld_r, held_vld_nxt;
  crm_out_t               held_r, held_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  crm_out_t               out_res_r, out_res_nxt;
  logic [MAP_DEPTH-1:0]   map_vld_r;
  logic                   map_rvld_r;

  logic [3:0]        nr;
  logic [5:0]        nc;
  logic              in_rng;
  logic              free_any;
  logic [SW-1:0]     free_idx;
  logic              excl_col;
  logic [7:0]        col8;
  logic              map_rd, map_we;
  logic [MAP_AW-1:0] map_raddr, map_waddr;
  logic [MW-1:0]     map_wdata, map_rdata, map_qv;
  logic              pul_we;
  logic [SW-1:0]     pul_raddr, pul_waddr;
  logic [PW-1:0]     pul_wdata, pul_rdata;
  logic [31:0]       p_start;
  logic [RW-1:0]     p_row;
  logic [CW-1:0]     p_col;
  logic [31:0]       p_age;
  logic              p_expired;
  logic              tk_last;
  logic              emit_vld;
  crm_out_t          emit_res;
  logic              d_on, d_change, d_target, d_drive, d_acc;
  logic [2:0]        d_cmd;
  logic [15:0]       d_lvl;

  function automatic logic lock_bit(input logic [RW-1:0] a, input logic [RW-1:0] b,
                                    input logic [15:0] locks);
    logic [6:0] k;
    k = 7'(a) * 7'(MAX_ROWS) + 7'(b);
    return (k < 7'd16) && locks[k[3:0]];
  endfunction

  function automatic crm_out_t mk_res(input logic [2:0] cmd, input logic [RW-1:0] r,
                                      input logic [CW-1:0] c, input logic [15:0] lvl,
                                      input logic acc, input logic lst);
    logic [7:0] r8;
    logic [7:0] c8;
    crm_out_t   o;
    r8          = 8'(r);
    c8          = 8'(c);
    o.command   = cmd;
    o.cmd_row   = r8[1:0];
    o.cmd_col   = c8[3:0];
    o.cmd_level = lvl;
    o.accepted  = acc;
    o.last      = lst;
    return o;
  endfunction

  crm_ram #(
    .WIDTH (MW),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  crm_ram #(
    .WIDTH (PW),
    .DEPTH (PULSE_SLOTS)
  ) u_pulse_ram (
    .clk   (clk),
    .we    (pul_we),
    .waddr (pul_waddr),
    .wdata (pul_wdata),
    .raddr (pul_raddr),
    .rdata (pul_rdata)
  );

  assign nr = ({1'b0, rows_in_use_r} > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : {1'b0, rows_in_use_r};
  assign nc = ({1'b0, cols_in_use_r} > 6'(MAX_COLS)) ? 6'(MAX_COLS) : {1'b0, cols_in_use_r};
  assign in_rng = (in_req.row < nr) && ({1'b0, in_req.col} < nc);

  assign col8     = 8'(req_col_r);
  assign excl_col = (col8 < 8'd16) && excl_cols_r[col8[3:0]];

  assign map_qv = map_rvld_r ? map_rdata : '0;

  assign {p_row, p_col, p_start} = pul_rdata;
  assign p_age     = tick_r - p_start;
  assign p_expired = p_age >= {16'd0, pulse_ticks_r};
  assign tk_last   = (6'(slot_r) == 6'(PULSE_SLOTS - 1));

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = PULSE_SLOTS - 1; i >= 0; i--) begin
      if (!act_vec_r[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    req_row_nxt    = req_row_r;
    req_col_nxt    = req_col_r;
    level_nxt      = level_r;
    rng_nxt        = rng_r;
    blk_nxt        = blk_r;
    tgt_nxt        = tgt_r;
    scan_nxt       = scan_r;
    chk_vld_nxt    = 1'b0;
    chk_row_nxt    = chk_row_r;
    cr_nxt         = cr_r;
    cc_nxt         = cc_r;
    clr_vld_nxt    = 1'b0;
    clr_row_nxt    = clr_row_r;
    clr_col_nxt    = clr_col_r;
    slot_nxt       = slot_r;
    tk_row_nxt     = tk_row_r;
    tk_col_nxt     = tk_col_r;
    tick_nxt       = tick_r;
    act_vec_nxt    = act_vec_r;
    held_vld_nxt   = held_vld_r;
    held_nxt       = held_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    map_rd         = 1'b0;
    map_raddr      = {scan_r, req_col_r};
    map_we         = 1'b0;
    map_waddr      = {req_row_r, req_col_r};
    map_wdata      = '0;
    pul_raddr      = slot_r;
    pul_we         = 1'b0;
    pul_waddr      = free_idx;
    pul_wdata      = {req_row_r, req_col_r, tick_r};
    emit_vld       = 1'b0;
    emit_res       = '0;
    d_on           = (level_r != 16'd0);
    d_change       = 1'b0;
    d_target       = 1'b0;
    d_drive        = 1'b0;
    d_acc          = 1'b0;
    d_cmd          = CMD_NONE;
    d_lvl          = '0;

    // Column scan data returning for a request.
    if (chk_vld_r) begin
      if (chk_row_r == req_row_r) begin
        tgt_nxt = map_qv;
      end else if ((lock_bit(req_row_r, chk_row_r, row_lock_r) ||
                    lock_bit(chk_row_r, req_row_r, row_lock_r) || excl_col) &&
                   (map_qv[E_CLOSED] || map_qv[E_PEND])) begin
        blk_nxt = 1'b1;
      end
    end

    // Node data returning during clear all.
    if (clr_vld_r && map_qv[E_CLOSED]) begin
      map_we    = 1'b1;
      map_waddr = {clr_row_r, clr_col_r};
      pul_wdata = {clr_row_r, clr_col_r, tick_r};
      if (latching_r) begin
        if (map_qv[E_PEND]) begin
          pul_we    = 1'b1;
          pul_waddr = map_qv[MW-1:2];
          map_wdata = {map_qv[MW-1:2], 1'b1, 1'b0};
          emit_vld  = 1'b1;
          emit_res  = mk_res(CMD_OPEN, clr_row_r, clr_col_r, '0, 1'b1, 1'b0);
        end else if (free_any) begin
          pul_we                = 1'b1;
          pul_waddr             = free_idx;
          act_vec_nxt[free_idx] = 1'b1;
          map_wdata             = {free_idx, 1'b1, 1'b0};
          emit_vld              = 1'b1;
          emit_res              = mk_res(CMD_OPEN, clr_row_r, clr_col_r, '0, 1'b1, 1'b0);
        end else begin
          map_wdata = {map_qv[MW-1:2], 1'b0, 1'b0};
        end
      end else begin
        map_wdata = {map_qv[MW-1:1], 1'b0};
        emit_vld  = 1'b1;
        emit_res  = mk_res(CMD_OPEN, clr_row_r, clr_col_r, '0, 1'b1, 1'b0);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt      = in_req.action;
          req_row_nxt  = in_req.row[RW-1:0];
          req_col_nxt  = in_req.col[CW-1:0];
          level_nxt    = in_req.level;
          rng_nxt      = in_rng;
          blk_nxt      = 1'b0;
          tgt_nxt      = '0;
          scan_nxt     = '0;
          cr_nxt       = '0;
          cc_nxt       = '0;
          slot_nxt     = '0;
          held_vld_nxt = 1'b0;
          unique case (in_req.action) inside
            ACT_CONNECT, ACT_DISCONNECT, ACT_SET_LEVEL: begin
              state_nxt = in_rng ? ST_SCAN : ST_DECIDE;
            end
            ACT_CLEAR_ALL: begin
              state_nxt = ((nr == 4'd0) || (nc == 6'd0)) ? ST_FIN : ST_CLR;
            end
            ACT_TICK: begin
              tick_nxt  = tick_r + 32'd1;
              state_nxt = latching_r ? ST_TK_RD : ST_FIN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        map_rd      = 1'b1;
        map_raddr   = {scan_r, req_col_r};
        chk_vld_nxt = 1'b1;
        chk_row_nxt = scan_r;
        if (4'(scan_r) == nr - 4'd1) begin
          state_nxt = ST_SCAN_LAST;
        end else begin
          scan_nxt = scan_r + RW'(1);
        end
      end
      ST_SCAN_LAST: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (rng_r) begin
          case (act_r)
            ACT_CONNECT: begin
              if (blk_r) begin
                d_acc = 1'b0;
              end else if (tgt_r[E_CLOSED]) begin
                d_acc = 1'b1;
              end else begin
                d_change = 1'b1;
                d_target = 1'b1;
                d_cmd    = CMD_CLOSE;
              end
            end
            ACT_DISCONNECT: begin
              if (!tgt_r[E_CLOSED]) begin
                d_acc = 1'b1;
              end else begin
                d_change = 1'b1;
                d_target = 1'b0;
                d_cmd    = CMD_OPEN;
              end
            end
            ACT_SET_LEVEL: begin
              if (d_on && blk_r) begin
                d_acc = 1'b0;
              end else if (latching_r && (tgt_r[E_CLOSED] == d_on)) begin
                d_acc = 1'b1;
              end else begin
                d_change = 1'b1;
                d_target = d_on;
                d_cmd    = CMD_SET;
                d_lvl    = level_r;
              end
            end
            default: begin
              d_acc = 1'b0;
            end
          endcase
        end
        if (d_change) begin
          if (latching_r) begin
            if (!tgt_r[E_PEND] && free_any) begin
              d_acc                 = 1'b1;
              d_drive               = 1'b1;
              d_cmd                 = d_target ? CMD_CLOSE : CMD_OPEN;
              d_lvl                 = '0;
              map_we                = 1'b1;
              map_wdata             = {free_idx, 1'b1, d_target};
              pul_we                = 1'b1;
              act_vec_nxt[free_idx] = 1'b1;
            end else begin
              d_acc = 1'b0;
            end
          end else begin
            d_acc     = 1'b1;
            d_drive   = 1'b1;
            map_we    = 1'b1;
            map_wdata = {tgt_r[MW-1:1], d_target};
          end
        end
        out_strobe_nxt = 1'b1;
        if (d_drive) begin
          out_res_nxt = mk_res(d_cmd, req_row_r, req_col_r, d_lvl, d_acc, 1'b1);
        end else begin
          out_res_nxt = mk_res(CMD_NONE, '0, '0, '0, d_acc, 1'b1);
        end
        state_nxt = ST_IDLE;
      end
      ST_CLR: begin
        map_rd      = 1'b1;
        map_raddr   = {cr_r, cc_r};
        clr_vld_nxt = 1'b1;
        clr_row_nxt = cr_r;
        clr_col_nxt = cc_r;
        if (6'(cc_r) == nc - 6'd1) begin
          cc_nxt = '0;
          if (4'(cr_r) == nr - 4'd1) begin
            state_nxt = ST_CLR_LAST;
          end else begin
            cr_nxt = cr_r + RW'(1);
          end
        end else begin
          cc_nxt = cc_r + CW'(1);
        end
      end
      ST_CLR_LAST: begin
        state_nxt = ST_FIN;
      end
      ST_TK_RD: begin
        pul_raddr = slot_r;
        if (act_vec_r[slot_r]) begin
          state_nxt = ST_TK_CHK;
        end else if (tk_last) begin
          state_nxt = ST_FIN;
        end else begin
          slot_nxt = slot_r + SW'(1);
        end
      end
      ST_TK_CHK: begin
        if (p_expired) begin
          map_rd              = 1'b1;
          map_raddr           = {p_row, p_col};
          tk_row_nxt          = p_row;
          tk_col_nxt          = p_col;
          act_vec_nxt[slot_r] = 1'b0;
          emit_vld            = 1'b1;
          emit_res            = mk_res(CMD_RELEASE, p_row, p_col, '0, 1'b1, 1'b0);
          state_nxt           = ST_TK_WR;
        end else if (tk_last) begin
          state_nxt = ST_FIN;
        end else begin
          slot_nxt  = slot_r + SW'(1);
          state_nxt = ST_TK_RD;
        end
      end
      ST_TK_WR: begin
        map_we    = 1'b1;
        map_waddr = {tk_row_r, tk_col_r};
        map_wdata = {map_qv[MW-1:2], 1'b0, map_qv[E_CLOSED]};
        if (tk_last) begin
          state_nxt = ST_FIN;
        end else begin
          slot_nxt  = slot_r + SW'(1);
          state_nxt = ST_TK_RD;
        end
      end
      ST_FIN: begin
        if (held_vld_r) begin
          out_strobe_nxt   = 1'b1;
          out_res_nxt      = held_r;
          out_res_nxt.last = 1'b1;
        end else if (act_r == ACT_CLEAR_ALL) begin
          out_strobe_nxt = 1'b1;
          out_res_nxt    = mk_res(CMD_NONE, '0, '0, '0, 1'b1, 1'b1);
        end
        held_vld_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // One result is held back so that the final one can carry the last flag.
    if (emit_vld) begin
      if (held_vld_r) begin
        out_strobe_nxt = 1'b1;
        out_res_nxt    = held_r;
      end
      held_nxt     = emit_res;
      held_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latching_r    <= 1'b0;
      pulse_ticks_r <= '0;
      rows_in_use_r <= 3'd4;
      cols_in_use_r <= 5'd16;
      row_lock_r    <= '0;
      excl_cols_r   <= '0;
      state_r       <= ST_IDLE;
      chk_vld_r     <= 1'b0;
      clr_vld_r     <= 1'b0;
      tick_r        <= '0;
      act_vec_r     <= '0;
      held_vld_r    <= 1'b0;
      out_strobe_r  <= 1'b0;
      map_vld_r     <= '0;
      map_rvld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LATCHING:    latching_r    <= cfg_data[0];
          CFG_PULSE_TICKS: pulse_ticks_r <= cfg_data;
          CFG_ROWS:        rows_in_use_r <= cfg_data[2:0];
          CFG_COLS:        cols_in_use_r <= cfg_data[4:0];
          CFG_ROW_LOCKS:   row_lock_r    <= cfg_data;
          CFG_EXCL_COLS:   excl_cols_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      state_r      <= state_nxt;
      chk_vld_r    <= chk_vld_nxt;
      clr_vld_r    <= clr_vld_nxt;
      tick_r       <= tick_nxt;
      act_vec_r    <= act_vec_nxt;
      held_vld_r   <= held_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      map_rvld_r   <= map_vld_r[map_raddr];
      if (map_we) begin
        map_vld_r[map_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    req_row_r <= req_row_nxt;
    req_col_r <= req_col_nxt;
    level_r   <= level_nxt;
    rng_r     <= rng_nxt;
    blk_r     <= blk_nxt;
    tgt_r     <= tgt_nxt;
    scan_r    <= scan_nxt;
    chk_row_r <= chk_row_nxt;
    cr_r      <= cr_nxt;
    cc_r      <= cc_nxt;
    clr_row_r <= clr_row_nxt;
    clr_col_r <= clr_col_nxt;
    slot_r    <= slot_nxt;
    tk_row_r  <= tk_row_nxt;
    tk_col_r  <= tk_col_nxt;
    held_r    <= held_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  `CRM_ASSERT_NEXT(a_accept_busy, start && !busy, busy,
                   "Accepted beat did not make the block busy.")
  `CRM_ASSERT_SAME(a_more_results, out_strobe && !out_res.last, busy,
                   "Non-final result shown after the sequencer went idle.")
  `CRM_ASSERT_SAME(a_none_is_last, out_strobe && (out_res.command == CMD_NONE), out_res.last,
                   "Result without a drive command is not the final one.")
  `CRM_ASSERT_SAME(a_map_rw_clash, map_we && map_rd, map_waddr != map_raddr,
                   "Node map read and written at the same entry in one cycle.")

endmodule
